@@ rtl/hbe_pkg.sv @@
package hbe_pkg;

    // field widths
    localparam int FREQ_W  = 24;
    localparam int RATIO_W = 16;
    localparam int RMS_W   = 16;
    localparam int ACC_W   = 42;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;

    // result transaction: rms, then the four band energies
    localparam int OUT_W = RMS_W + 4 * ACC_W;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // register map, index = paddr / 4
    localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATED_SHAFT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HALFWIDTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HF_RATIO    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd4;

    // reset values of the registers
    localparam logic [FREQ_W-1:0]  RST_BIN_WIDTH   = 24'd256;
    localparam logic [FREQ_W-1:0]  RST_RATED_SHAFT = 24'd6400;
    localparam logic [FREQ_W-1:0]  RST_HALFWIDTH   = 24'd512;
    localparam logic [RATIO_W-1:0] RST_HF_RATIO    = 16'd1280;
    localparam logic [FREQ_W-1:0]  RST_SAMPLE_RATE = 24'd256000;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [FREQ_W-1:0]  bin_width;
        logic [FREQ_W-1:0]  rated_shaft;
        logic [FREQ_W-1:0]  halfwidth;
        logic [RATIO_W-1:0] hf_ratio;
        logic [FREQ_W-1:0]  sample_rate;
    } hbe_cfg_t;

    // per-bin tag produced by the front
    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             first;
        logic             last;
        logic [3:0]       mask;
    } hbe_tag_t;

endpackage

@@ rtl/harmonic_band_energy.sv @@
// result path: the frame's last bin passes the queue, the square stage and the result register
// throughput: one bin per cycle while the queue is not full; band edges are set in the first bin's
// cycle and compared against running multiples of the bin width, so no division stalls
// a 4-entry queue parts the bin-accepting front from the square/accumulate back
// reset: rst_n asynchronous active low; registers return to their defaults,
// bin counter, queue and pipeline valids clear; no memory clearing pass
module harmonic_band_energy
    import hbe_pkg::*;
#(
    parameter int NUM_BINS  = 512,
    parameter int MAG_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // apb configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // bin stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // magnitude, shaft_hz, frame_rms (lowest bit up), zero padded to bytes
    input  logic [((MAG_WIDTH + FREQ_W + RMS_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic               s_axis_tlast,
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // rms_out, h1_energy, h2_energy, h3_energy, hf_energy (lowest bit up)
    output logic [OUT_W-1:0]   m_axis_tdata
);

    localparam int IN_W = ((MAG_WIDTH + FREQ_W + RMS_W + 7) / 8) * 8;
    localparam int QW   = $bits(hbe_tag_t) + MAG_WIDTH;

    hbe_cfg_t        cfg;
    logic            q_push;
    logic [QW-1:0]   q_push_data;
    logic            q_pop;
    logic [QW-1:0]   q_pop_data;
    logic            q_not_empty;
    logic            q_full;

    hbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbe_front #(
        .NUM_BINS  (NUM_BINS),
        .MAG_WIDTH (MAG_WIDTH),
        .IN_W      (IN_W),
        .QW        (QW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    hbe_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    hbe_back #(
        .MAG_WIDTH (MAG_WIDTH),
        .QW        (QW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/hbe_regs.sv @@
module hbe_regs
    import hbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output hbe_cfg_t           cfg
);

    logic [FREQ_W-1:0]    bin_width_reg;
    logic [FREQ_W-1:0]    rated_shaft_reg;
    logic [FREQ_W-1:0]    halfwidth_reg;
    logic [RATIO_W-1:0]   hf_ratio_reg;
    logic [FREQ_W-1:0]    sample_rate_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg   <= RST_BIN_WIDTH;
            rated_shaft_reg <= RST_RATED_SHAFT;
            halfwidth_reg   <= RST_HALFWIDTH;
            hf_ratio_reg    <= RST_HF_RATIO;
            sample_rate_reg <= RST_SAMPLE_RATE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_BIN_WIDTH:   bin_width_reg   <= pwdata[FREQ_W-1:0];
                REG_RATED_SHAFT: rated_shaft_reg <= pwdata[FREQ_W-1:0];
                REG_HALFWIDTH:   halfwidth_reg   <= pwdata[FREQ_W-1:0];
                REG_HF_RATIO:    hf_ratio_reg    <= pwdata[RATIO_W-1:0];
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[FREQ_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_BIN_WIDTH:   prdata = DATA_W'(bin_width_reg);
            REG_RATED_SHAFT: prdata = DATA_W'(rated_shaft_reg);
            REG_HALFWIDTH:   prdata = DATA_W'(halfwidth_reg);
            REG_HF_RATIO:    prdata = DATA_W'(hf_ratio_reg);
            REG_SAMPLE_RATE: prdata = DATA_W'(sample_rate_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.bin_width   = bin_width_reg;
    assign cfg.rated_shaft = rated_shaft_reg;
    assign cfg.halfwidth   = halfwidth_reg;
    assign cfg.hf_ratio    = hf_ratio_reg;
    assign cfg.sample_rate = sample_rate_reg;

endmodule

@@ rtl/hbe_front.sv @@
module hbe_front
    import hbe_pkg::*;
#(
    parameter int NUM_BINS  = 512,
    parameter int MAG_WIDTH = 16,
    parameter int IN_W      = 56,
    parameter int QW        = 38
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  hbe_cfg_t        cfg,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,
    input  logic            s_axis_tlast,
    input  logic            q_full,
    output logic            q_push,
    output logic [QW-1:0]   q_push_data
);

    localparam int CW     = $clog2(NUM_BINS + 1);
    localparam int KW     = FREQ_W + $clog2(NUM_BINS + 2);
    localparam int CMP_W  = KW + 16;
    localparam int TH_W   = FREQ_W + 3;
    localparam int RR_W   = FREQ_W + RATIO_W;

    // bin counter and running edge products (k+1)*bw and (k-1)*bw
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [KW-1:0]     kp1_reg, kp1_next;
    logic [KW-1:0]     km1_reg, km1_next;
    logic [FREQ_W-1:0] den_reg;
    logic [FREQ_W-1:0] sr_reg;
    logic [RR_W-1:0]   rr_reg;
    logic [TH_W-1:0]   lo_th_reg [3];
    logic [TH_W-1:0]   hi_th_reg [3];

    logic [MAG_WIDTH-1:0] mag;
    logic [FREQ_W-1:0]    shaft;
    logic [RMS_W-1:0]     rms;
    logic                 accept;
    logic                 first;
    logic                 in_span;
    logic [FREQ_W-1:0]    den;
    logic [FREQ_W-1:0]    f1;
    logic [TH_W-1:0]      f1_x;
    logic [TH_W-1:0]      hw_x;
    logic [TH_W-1:0]      harm [3];
    logic [TH_W-1:0]      lo_th [3];
    logic [TH_W-1:0]      hi_th [3];
    logic [3:0]           mask;
    hbe_tag_t             tag;

    assign mag   = s_axis_tdata[MAG_WIDTH-1:0];
    assign shaft = s_axis_tdata[MAG_WIDTH +: FREQ_W];
    assign rms   = s_axis_tdata[MAG_WIDTH + FREQ_W +: RMS_W];

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign first         = (cnt_reg == '0);
    assign in_span       = (cnt_reg < CW'(NUM_BINS));

    // frame setup: shaft frequency and band edge numerators
    assign den  = (cfg.bin_width != '0) ? cfg.bin_width : FREQ_W'(1);
    assign f1   = (shaft != '0) ? shaft : cfg.rated_shaft;
    assign f1_x = TH_W'(f1);
    assign hw_x = TH_W'(cfg.halfwidth);

    always_comb
    begin
        harm[0] = f1_x;
        harm[1] = f1_x << 1;
        harm[2] = f1_x + (f1_x << 1);
        for (int h = 0; h < 3; h++)
        begin
            lo_th[h] = (harm[h] >= hw_x) ? (harm[h] - hw_x) : '0;
            hi_th[h] = harm[h] + hw_x;
        end
    end

    // band membership of the current bin, by cross-multiplied edges
    always_comb
    begin
        for (int h = 0; h < 3; h++)
        begin
            mask[h] = !first && in_span
                      && (CMP_W'(kp1_reg) > CMP_W'(lo_th_reg[h]))
                      && (CMP_W'(km1_reg) < CMP_W'(hi_th_reg[h]));
        end
        mask[3] = !first && in_span
                  && (CMP_W'({kp1_reg, 8'b0}) > CMP_W'(rr_reg))
                  && (CMP_W'({km1_reg, 1'b0}) < CMP_W'(sr_reg));
    end

    // counter and edge product update
    always_comb
    begin
        cnt_next = cnt_reg;
        kp1_next = kp1_reg;
        km1_next = km1_reg;
        if (accept)
        begin
            if (s_axis_tlast)
                cnt_next = '0;
            else if (in_span)
                cnt_next = cnt_reg + CW'(1);
            if (first)
            begin
                kp1_next = KW'(den) << 1;
                km1_next = '0;
            end
            else if (in_span)
            begin
                kp1_next = kp1_reg + KW'(den_reg);
                km1_next = km1_reg + KW'(den_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        kp1_reg <= kp1_next;
        km1_reg <= km1_next;
        if (accept && first)
        begin
            den_reg <= den;
            sr_reg  <= cfg.sample_rate;
            rr_reg  <= RR_W'(cfg.rated_shaft) * RR_W'(cfg.hf_ratio);
            for (int h = 0; h < 3; h++)
            begin
                lo_th_reg[h] <= lo_th[h];
                hi_th_reg[h] <= hi_th[h];
            end
        end
    end

    // queue write
    assign tag.rms   = rms;
    assign tag.first = first;
    assign tag.last  = s_axis_tlast;
    assign tag.mask  = mask;

    assign q_push      = accept;
    assign q_push_data = {tag, mag};

endmodule

@@ rtl/hbe_queue.sv @@
module hbe_queue
#(
    parameter int WIDTH = 38,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == NW'(DEPTH));
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/hbe_back.sv @@
module hbe_back
    import hbe_pkg::*;
#(
    parameter int MAG_WIDTH = 16,
    parameter int QW        = 38
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic [QW-1:0]    q_data,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int SQ_W  = 2 * MAG_WIDTH;
    localparam int SUM_W = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;

    // square stage
    logic                 s1_valid_reg, s1_valid_next;
    hbe_tag_t             s1_tag_reg;
    logic [SQ_W-1:0]      sq_reg;

    // accumulate stage and result register
    logic [ACC_W-1:0]     acc_reg [4];
    logic [ACC_W-1:0]     acc_next [4];
    logic [RMS_W-1:0]     held_rms_reg, held_rms_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg;

    hbe_tag_t             q_tag;
    logic [MAG_WIDTH-1:0] q_mag;
    logic                 out_free;
    logic                 adv;
    logic [SUM_W-1:0]     sum [4];

    assign q_tag = q_data[QW-1:MAG_WIDTH];
    assign q_mag = q_data[MAG_WIDTH-1:0];

    // handshake between stages
    assign out_free = !out_valid_reg || m_axis_tready;
    assign adv      = s1_valid_reg && (!s1_tag_reg.last || out_free);
    assign q_pop    = q_valid && (!s1_valid_reg || adv);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_pop)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
    end

    // saturating band sums, cleared at frame start
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = (s1_tag_reg.first ? '0 : SUM_W'(acc_reg[i]))
                     + (s1_tag_reg.mask[i] ? SUM_W'(sq_reg) : '0);
            acc_next[i] = (sum[i] > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[i][ACC_W-1:0];
        end
        held_rms_next = s1_tag_reg.first ? s1_tag_reg.rms : held_rms_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && s1_tag_reg.last)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_tag_reg <= q_tag;
            sq_reg     <= {{MAG_WIDTH{1'b0}}, q_mag} * {{MAG_WIDTH{1'b0}}, q_mag};
        end
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= acc_next[i];
            held_rms_reg <= held_rms_next;
            if (s1_tag_reg.last)
                out_data_reg <= {acc_next[3], acc_next[2], acc_next[1], acc_next[0],
                                 held_rms_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the frame's first bin lies below every band
    a_first_no_band: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_tag_reg.first) |-> (s1_tag_reg.mask == 4'b0))
        else $error("first bin of a frame matched a band");

    // a result appears only after a last bin moved into the sums
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(adv) && $past(s1_tag_reg.last)))
        else $error("result raised without a last bin");

    // a blocked last bin keeps its square and stays put
    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_tag_reg.last && out_valid_reg && !m_axis_tready)
        |=> (s1_valid_reg && $stable(sq_reg)))
        else $error("blocked last bin was lost");

    // the queue is read only when it holds an entry
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
